FILE: hw/rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPARE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   address;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_START,
    OP_WALK,
    OP_MARK,
    OP_POP_RD,
    OP_POP_WM,
    OP_POP,
    OP_SPLIT_NEW,
    OP_SPLIT_LINK,
    OP_SPLIT_CUR,
    OP_RD_NEXT,
    OP_MERGE_NX,
    OP_LINK_CUR,
    OP_RD_PREV,
    OP_MERGE_PV,
    OP_PUSH_CUR,
    OP_LINK_AUX,
    OP_WR_CUR
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic zero_size;
    logic is_free;
    logic exact;
    logic spare_ok;
    logic wm_ok;
    logic rnext_none;
    logic rprev_none;
    logic rd_alloc;
  } dp_stat_t;

endpackage

FILE: hw/rtl/ffba_dpath.sv
module ffba_dpath import ffba_pkg::*; #(
  parameter int unsigned DESCRIPTORS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  input  in_item_t             in_data_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output out_item_t            out_data_o
);

  localparam int unsigned IdxW = $clog2(DESCRIPTORS);
  localparam int unsigned LinkW = IdxW + 1;
  localparam logic [LinkW-1:0] NoLink = LinkW'(DESCRIPTORS);

  // descriptor table, one memory per field
  logic [DATA_W-1:0] start_mem [DESCRIPTORS];
  logic [DATA_W-1:0] len_mem   [DESCRIPTORS];
  logic              alloc_mem [DESCRIPTORS];
  logic [LinkW-1:0]  next_mem  [DESCRIPTORS];
  logic [LinkW-1:0]  prev_mem  [DESCRIPTORS];

  logic [IdxW-1:0]   wa, ra;
  logic              we_start, we_len, we_alloc, we_next, we_prev;
  logic [DATA_W-1:0] wd_start, wd_len;
  logic              wd_alloc;
  logic [LinkW-1:0]  wd_next, wd_prev;

  logic [DATA_W-1:0] rd_start, rd_len;
  logic              rd_alloc;
  logic [LinkW-1:0]  rd_next, rd_prev;

  logic [DATA_W-1:0] region_start_q, region_end_q;
  logic [LinkW-1:0]  spare_q, wm_q;
  logic              cmd_q;
  logic [DATA_W-1:0] size_q, faddr_q;
  logic [IdxW-1:0]   cur_q, rd_idx_q, aux_q;
  logic [DATA_W-1:0] r_start_q, r_len_q;
  logic [LinkW-1:0]  r_next_q, r_prev_q;
  out_item_t         out_q;

  logic [DATA_W-1:0] head_len;
  logic              rnext_none;

  assign head_len = (region_end_q >= region_start_q) ? (region_end_q - region_start_q) : '0;
  assign rnext_none = (r_next_q == NoLink);

  assign stat_o.hit = (cmd_q == CMD_FREE) ? (rd_alloc && (rd_start == faddr_q))
                                          : (!rd_alloc && (rd_len >= size_q));
  assign stat_o.last       = (rd_next == NoLink);
  assign stat_o.zero_size  = (size_q == '0);
  assign stat_o.is_free    = (cmd_q == CMD_FREE);
  assign stat_o.exact      = (r_len_q == size_q);
  assign stat_o.spare_ok   = (spare_q != NoLink);
  assign stat_o.wm_ok      = (wm_q != NoLink);
  assign stat_o.rnext_none = rnext_none;
  assign stat_o.rprev_none = (r_prev_q == NoLink);
  assign stat_o.rd_alloc   = rd_alloc;

  assign out_data_o = out_q;

  always_comb begin
    wa = '0;
    ra = '0;
    we_start = 1'b0;
    we_len = 1'b0;
    we_alloc = 1'b0;
    we_next = 1'b0;
    we_prev = 1'b0;
    wd_start = '0;
    wd_len = '0;
    wd_alloc = 1'b0;
    wd_next = NoLink;
    wd_prev = NoLink;
    unique case (cmd_i.op)
      OP_INIT: begin
        we_start = 1'b1;
        we_len = 1'b1;
        we_alloc = 1'b1;
        we_next = 1'b1;
        we_prev = 1'b1;
        wd_start = region_start_q;
        wd_len = head_len;
      end
      OP_WALK:   ra = rd_next[IdxW-1:0];
      OP_POP_RD: ra = spare_q[IdxW-1:0];
      OP_RD_NEXT: ra = r_next_q[IdxW-1:0];
      OP_RD_PREV: ra = r_prev_q[IdxW-1:0];
      OP_MARK: begin
        wa = cur_q;
        we_alloc = 1'b1;
        wd_alloc = 1'b1;
      end
      OP_SPLIT_NEW: begin
        wa = aux_q;
        we_start = 1'b1;
        we_len = 1'b1;
        we_alloc = 1'b1;
        we_next = 1'b1;
        we_prev = 1'b1;
        wd_start = r_start_q + size_q;
        wd_len = r_len_q - size_q;
        wd_next = r_next_q;
        wd_prev = {1'b0, cur_q};
      end
      OP_SPLIT_LINK: begin
        wa = r_next_q[IdxW-1:0];
        we_prev = !rnext_none;
        wd_prev = {1'b0, aux_q};
      end
      OP_SPLIT_CUR: begin
        wa = cur_q;
        we_len = 1'b1;
        we_next = 1'b1;
        we_alloc = 1'b1;
        wd_len = size_q;
        wd_next = {1'b0, aux_q};
        wd_alloc = 1'b1;
      end
      OP_MERGE_NX: begin
        // push the absorbed neighbor onto the spare list
        wa = aux_q;
        we_next = 1'b1;
        wd_next = spare_q;
      end
      OP_LINK_CUR: begin
        wa = r_next_q[IdxW-1:0];
        we_prev = !rnext_none;
        wd_prev = {1'b0, cur_q};
      end
      OP_MERGE_PV: begin
        wa = aux_q;
        we_len = 1'b1;
        we_next = 1'b1;
        wd_len = rd_len + r_len_q;
        wd_next = r_next_q;
      end
      OP_PUSH_CUR: begin
        wa = cur_q;
        we_next = 1'b1;
        wd_next = spare_q;
      end
      OP_LINK_AUX: begin
        wa = r_next_q[IdxW-1:0];
        we_prev = !rnext_none;
        wd_prev = {1'b0, aux_q};
      end
      OP_WR_CUR: begin
        wa = cur_q;
        we_alloc = 1'b1;
        we_len = 1'b1;
        we_next = 1'b1;
        wd_len = r_len_q;
        wd_next = r_next_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_start) start_mem[wa] <= wd_start;
    rd_start <= start_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_len) len_mem[wa] <= wd_len;
    rd_len <= len_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_alloc) alloc_mem[wa] <= wd_alloc;
    rd_alloc <= alloc_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_next) next_mem[wa] <= wd_next;
    rd_next <= next_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_prev) prev_mem[wa] <= wd_prev;
    rd_prev <= prev_mem[ra];
  end

  // region registers, spare list head and watermark of never-used descriptors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      region_end_q <= '0;
      spare_q <= NoLink;
      wm_q <= LinkW'(1);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REGION_START: region_start_q <= cfg_wdata_i;
          CFG_REGION_END:   region_end_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      unique case (cmd_i.op)
        OP_INIT: begin
          spare_q <= NoLink;
          wm_q <= LinkW'(1);
        end
        OP_POP_WM:   wm_q <= wm_q + LinkW'(1);
        OP_POP:      spare_q <= rd_next;
        OP_MERGE_NX: spare_q <= {1'b0, aux_q};
        OP_PUSH_CUR: spare_q <= {1'b0, cur_q};
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_START: begin
        cmd_q <= in_data_i.command;
        size_q <= in_data_i.request_size;
        faddr_q <= in_data_i.free_address;
        rd_idx_q <= '0;
      end
      OP_WALK: begin
        r_start_q <= rd_start;
        r_len_q <= rd_len;
        r_next_q <= rd_next;
        r_prev_q <= rd_prev;
        cur_q <= rd_idx_q;
        rd_idx_q <= rd_next[IdxW-1:0];
      end
      OP_POP_RD:  aux_q <= spare_q[IdxW-1:0];
      OP_POP_WM:  aux_q <= wm_q[IdxW-1:0];
      OP_RD_NEXT: aux_q <= r_next_q[IdxW-1:0];
      OP_RD_PREV: aux_q <= r_prev_q[IdxW-1:0];
      OP_MERGE_NX: begin
        r_len_q <= r_len_q + rd_len;
        r_next_q <= rd_next;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      out_q.status <= cmd_i.out_status;
      out_q.address <= ((cmd_i.out_status == ST_OK) && (cmd_q == CMD_ALLOC)) ? r_start_q : '0;
    end
  end

endmodule

FILE: hw/rtl/ffba_ctrl.sv
module ffba_ctrl import ffba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rebuild_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_WALK,
    S_A_FIT, S_A_POP, S_A_SPL1, S_A_SPL2, S_A_SPL3,
    S_F_FOUND, S_F_NX, S_F_NXA, S_F_PV, S_F_PVC, S_F_PUSH, S_F_PVA, S_F_WCUR,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                out_valid_q, out_valid_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    status_d = status_q;
    cmd_o.op = OP_NONE;
    cmd_o.out_load = 1'b0;
    cmd_o.out_status = status_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.op = OP_WALK;
        priority if (!stat_i.is_free && stat_i.zero_size) begin
          status_d = ST_ZERO;
          state_d = S_DONE;
        end else if (stat_i.hit) begin
          state_d = stat_i.is_free ? S_F_FOUND : S_A_FIT;
        end else if (stat_i.last) begin
          status_d = stat_i.is_free ? ST_NOTALLOC : ST_NOFIT;
          state_d = S_DONE;
        end
      end
      S_A_FIT: begin
        priority if (stat_i.exact) begin
          cmd_o.op = OP_MARK;
          status_d = ST_OK;
          state_d = S_DONE;
        end else if (stat_i.spare_ok) begin
          cmd_o.op = OP_POP_RD;
          state_d = S_A_POP;
        end else if (stat_i.wm_ok) begin
          cmd_o.op = OP_POP_WM;
          state_d = S_A_SPL1;
        end else begin
          status_d = ST_NOSPARE;
          state_d = S_DONE;
        end
      end
      S_A_POP: begin
        cmd_o.op = OP_POP;
        state_d = S_A_SPL1;
      end
      S_A_SPL1: begin
        cmd_o.op = OP_SPLIT_NEW;
        state_d = S_A_SPL2;
      end
      S_A_SPL2: begin
        cmd_o.op = OP_SPLIT_LINK;
        state_d = S_A_SPL3;
      end
      S_A_SPL3: begin
        cmd_o.op = OP_SPLIT_CUR;
        status_d = ST_OK;
        state_d = S_DONE;
      end
      S_F_FOUND: begin
        if (stat_i.rnext_none) begin
          state_d = S_F_PV;
        end else begin
          cmd_o.op = OP_RD_NEXT;
          state_d = S_F_NX;
        end
      end
      S_F_NX: begin
        if (stat_i.rd_alloc) begin
          state_d = S_F_PV;
        end else begin
          cmd_o.op = OP_MERGE_NX;
          state_d = S_F_NXA;
        end
      end
      S_F_NXA: begin
        cmd_o.op = OP_LINK_CUR;
        state_d = S_F_PV;
      end
      S_F_PV: begin
        if (stat_i.rprev_none) begin
          state_d = S_F_WCUR;
        end else begin
          cmd_o.op = OP_RD_PREV;
          state_d = S_F_PVC;
        end
      end
      S_F_PVC: begin
        if (stat_i.rd_alloc) begin
          state_d = S_F_WCUR;
        end else begin
          cmd_o.op = OP_MERGE_PV;
          state_d = S_F_PUSH;
        end
      end
      S_F_PUSH: begin
        cmd_o.op = OP_PUSH_CUR;
        state_d = S_F_PVA;
      end
      S_F_PVA: begin
        cmd_o.op = OP_LINK_AUX;
        status_d = ST_OK;
        state_d = S_DONE;
      end
      S_F_WCUR: begin
        cmd_o.op = OP_WR_CUR;
        status_d = ST_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
    if (rebuild_i) begin
      state_d = S_INIT;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      status_q <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      status_q <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator. Each transaction is accepted, then walks the list, visiting one
// descriptor per cycle through the descriptor table's single read port; then it splits the
// block on an allocate or merges free neighbors on a free, and hands the result to the
// output register once that register is free. A new transaction is taken while the previous
// result still waits at the output. After reset and after every configuration write the
// table is rebuilt as one free block, during which in_stall_o is high.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned DESCRIPTORS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     rebuild;

  assign rebuild = cfg_we_i &&
                   ((cfg_idx_i == CFG_REGION_START) || (cfg_idx_i == CFG_REGION_END));

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rebuild_i   (rebuild),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffba_dpath #(
    .DESCRIPTORS (DESCRIPTORS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("table rebuild did not block input");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction taken while busy");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= ST_ZERO))
    else $error("status code out of range");

  a_addr_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_OK)) |-> (out_data_o.address == '0))
    else $error("nonzero address on failed transaction");

endmodule

FILE: verif/testbench.sv
module testbench;
  import ffba_pkg::*;

  localparam int unsigned NDESC = 256;
  localparam int unsigned NONE = NDESC;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;

  // Table model plus the queue of pending results.
  class alloc_scoreboard;
    logic [DATA_W-1:0] blk_start[NDESC];
    logic [DATA_W-1:0] blk_len[NDESC];
    bit                blk_used[NDESC];
    bit                blk_taken[NDESC];
    int unsigned       blk_next[NDESC];
    int unsigned       blk_prev[NDESC];
    logic [DATA_W-1:0] reg_start;
    logic [DATA_W-1:0] reg_end;
    out_item_t         pending[$];
    int                errors;
    int                checked;
    int                by_status[8];

    function new();
      reg_start = '0;
      reg_end = '0;
      errors = 0;
      checked = 0;
      foreach (by_status[i]) by_status[i] = 0;
      rebuild();
    endfunction

    function void clear_entry(int unsigned i);
      blk_start[i] = '0;
      blk_len[i] = '0;
      blk_used[i] = 0;
      blk_taken[i] = 0;
      blk_next[i] = NONE;
      blk_prev[i] = NONE;
    endfunction

    function void rebuild();
      for (int unsigned i = 0; i < NDESC; i++) clear_entry(i);
      blk_used[0] = 1;
      blk_start[0] = reg_start;
      blk_len[0] = (reg_end >= reg_start) ? reg_end - reg_start : '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      if (idx == CFG_REGION_START) reg_start = val;
      else reg_end = val;
      rebuild();
    endfunction

    function out_item_t alloc(logic [DATA_W-1:0] size);
      out_item_t   r;
      int unsigned cur, steps, spare, nx;
      r = '0;
      if (size == 0) begin
        r.status = ST_ZERO;
        return r;
      end
      cur = 0;
      for (steps = 0; steps < NDESC && cur < NDESC; steps++) begin
        if (!blk_taken[cur] && blk_len[cur] >= size) break;
        cur = blk_next[cur];
      end
      if (steps >= NDESC || cur >= NDESC) begin
        r.status = ST_NOFIT;
        return r;
      end
      if (blk_len[cur] > size) begin
        spare = NONE;
        for (int unsigned i = 0; i < NDESC; i++)
          if (!blk_used[i]) begin
            spare = i;
            break;
          end
        if (spare == NONE) begin
          r.status = ST_NOSPARE;
          return r;
        end
        nx = blk_next[cur];
        blk_used[spare] = 1;
        blk_taken[spare] = 0;
        blk_start[spare] = blk_start[cur] + size;
        blk_len[spare] = blk_len[cur] - size;
        blk_next[spare] = nx;
        blk_prev[spare] = cur;
        if (nx < NDESC) blk_prev[nx] = spare;
        blk_next[cur] = spare;
        blk_len[cur] = size;
      end
      blk_taken[cur] = 1;
      r.status = ST_OK;
      r.address = blk_start[cur];
      return r;
    endfunction

    function out_item_t release_block(logic [DATA_W-1:0] addr);
      out_item_t   r;
      int unsigned cur, steps, nx, pv, after;
      r = '0;
      cur = 0;
      for (steps = 0; steps < NDESC && cur < NDESC; steps++) begin
        if (blk_taken[cur] && blk_start[cur] == addr) break;
        cur = blk_next[cur];
      end
      if (steps >= NDESC || cur >= NDESC) begin
        r.status = ST_NOTALLOC;
        return r;
      end
      blk_taken[cur] = 0;
      nx = blk_next[cur];
      if (nx < NDESC && !blk_taken[nx]) begin
        after = blk_next[nx];
        blk_len[cur] += blk_len[nx];
        blk_next[cur] = after;
        if (after < NDESC) blk_prev[after] = cur;
        clear_entry(nx);
      end
      pv = blk_prev[cur];
      if (pv < NDESC && !blk_taken[pv]) begin
        after = blk_next[cur];
        blk_len[pv] += blk_len[cur];
        blk_next[pv] = after;
        if (after < NDESC) blk_prev[after] = pv;
        clear_entry(cur);
      end
      r.status = ST_OK;
      return r;
    endfunction

    // Start of a random allocated block, or a random address if none.
    function logic [DATA_W-1:0] pick_taken();
      logic [DATA_W-1:0] starts[$];
      for (int unsigned i = 0; i < NDESC; i++)
        if (blk_used[i] && blk_taken[i]) starts.push_back(blk_start[i]);
      if (starts.size() == 0) return $urandom();
      return starts[$urandom_range(starts.size() - 1)];
    endfunction

    function void note(in_item_t it);
      if (it.command == CMD_ALLOC) pending.push_back(alloc(it.request_size));
      else pending.push_back(release_block(it.free_address));
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      errors++;
      $display("mismatch %0s: got 0x%08h, want 0x%08h (result %0d)", what, got, want, checked);
    endtask

    task check(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.address, '0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.address !== want.address) report("address", got.address, want.address);
      by_status[want.status]++;
      checked++;
    endtask
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 0;
  logic                 in_stall_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 0;
  out_item_t            out_data_o;

  alloc_scoreboard sb = new();
  bit          calm = 0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  int          stall_left = 0;

  first_fit_block_allocator #(.DESCRIPTORS(NDESC)) uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stall bursts, result checking, watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check(out_data_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
    if (calm) begin
      out_stall_i <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1;
    end else if ($urandom_range(7) == 0) begin
      stall_left <= $urandom_range(5);
      out_stall_i <= 1;
    end else begin
      out_stall_i <= 0;
    end
  end

  task automatic send(in_item_t it);
    int unsigned gap;
    if (!calm && $urandom_range(5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(it);
    sent++;
  endtask

  task automatic do_alloc(logic [DATA_W-1:0] size);
    in_item_t it;
    it.command = CMD_ALLOC;
    it.request_size = size;
    it.free_address = $urandom();
    send(it);
  endtask

  task automatic do_free(logic [DATA_W-1:0] addr);
    in_item_t it;
    it.command = CMD_FREE;
    it.request_size = $urandom();
    it.free_address = addr;
    send(it);
  endtask

  // Hold off until all results are back and the block is idle, then reprogram.
  task automatic set_region(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= CFG_REGION_START;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    sb.write_reg(CFG_REGION_START, lo);
    cfg_idx_i <= CFG_REGION_END;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    sb.write_reg(CFG_REGION_END, hi);
    cfg_we_i <= 0;
  endtask

  task automatic random_phase(int unsigned count, logic [DATA_W-1:0] span);
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) do_alloc($urandom_range(1, 24));
      else if (pick < 50) do_alloc($urandom_range(1, span));
      else if (pick < 85) do_free(sb.pick_taken());
      else if (pick < 90) do_alloc($urandom());
      else if (pick < 93) do_alloc('0);
      else if (pick < 97) do_free($urandom());
      else do_free(sb.pick_taken() + 1);
    end
  endtask

  initial begin
    logic [DATA_W-1:0] base, span;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset region is empty.
    do_alloc('0);
    do_alloc(1);
    do_free('0);

    set_region(32'h100, 32'h200);
    do_alloc(32'h10);
    do_alloc(32'h20);
    do_alloc(32'hd0);        // exact fit of the tail
    do_alloc(1);
    do_free(32'h110);
    do_free(32'h100);        // merge with free next
    do_free(32'h130);        // merge with free previous
    do_free(32'h130);
    do_alloc(32'hffffffff);
    do_alloc(32'h100);
    do_free(32'h100);

    set_region(32'h0, 32'hffffffff);
    do_alloc(32'hffffffff);
    do_free(32'h0);
    do_alloc(32'h80000000);

    // End below start: empty region.
    set_region(32'hfffffff0, 32'h10);
    do_alloc(1);
    do_free(32'hfffffff0);

    // Small regions with random allocate and free traffic.
    for (int p = 0; p < 6; p++) begin
      span = $urandom_range(64, 4096);
      base = $urandom();
      if (base > 32'hffffffff - span) base = 32'hffffffff - span;
      set_region(base, base + span);
      random_phase(150, span);
    end
    set_region(32'h0, 32'hffffffff);
    random_phase(60, 32'hffffffff);

    set_region(32'h1000, 32'h1400);
    calm = 1;
    random_phase(80, 32'h400);

    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending.size() != 0) sb.report("missing results", sb.pending.size(), '0);
    $display("sent %0d requests over 11 region settings, checked %0d results", sent, sb.checked);
    $display("ok %0d, no fit %0d, no spare %0d, not allocated %0d, zero size %0d",
             sb.by_status[ST_OK], sb.by_status[ST_NOFIT], sb.by_status[ST_NOSPARE],
             sb.by_status[ST_NOTALLOC], sb.by_status[ST_ZERO]);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
